>>> design/scqc_pkg.sv
// Shared types and constants of the stake quorum certificate checker.
// Request, status, certificate phase and sequencer codes, and the adder request.
// No dependencies.
package scqc_pkg;

	localparam int STAKE_W  = 64;
	localparam int INDEX_W  = 32;
	localparam int SIGNER_W = 11;
	localparam int ALU_W    = 67;

	typedef enum logic [1:0] {
		REQ_LOAD   = 2'd0,
		REQ_BEGIN  = 2'd1,
		REQ_ABSORB = 2'd2,
		REQ_FINISH = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_ARGUMENT  = 3'd1,
		ST_SNAPSHOT  = 3'd2,
		ST_CLOSED    = 3'd3,
		ST_ORDER     = 3'd4,
		ST_RANGE     = 3'd5,
		ST_SIGNATURE = 3'd6,
		ST_BELOW     = 3'd7
	} status_t;

	typedef enum logic [1:0] {
		PH_IDLE     = 2'd0,
		PH_OPEN     = 2'd1,
		PH_ACCEPTED = 2'd2,
		PH_REJECTED = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		SQ_IDLE,
		SQ_READ,
		SQ_ADD,
		SQ_CMP,
		SQ_DONE
	} seq_state_t;

	typedef struct packed {
		logic [ALU_W-1:0] a;
		logic [ALU_W-1:0] b;
		logic             cin;
	} alu_req_t;

endpackage

>>> design/scqc_addsub.sv
// Shared 67-bit adder of the quorum checker: sums and, with an inverted
// operand and carry in, differences. Depends on scqc_pkg.
module scqc_addsub
	import scqc_pkg::*;
(
	input  alu_req_t         req,
	output logic [ALU_W-1:0] res
);

	assign res = req.a + req.b + ALU_W'(req.cin);

endmodule

>>> design/scqc_stake_ram.sv
// Stake table memory: one write port, one read port with registered data.
// Depends on scqc_pkg.
module scqc_stake_ram
	import scqc_pkg::*;
#(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
)
(
	input  logic               clk,
	input  logic               wr_en,
	input  logic [AW-1:0]      wr_addr,
	input  logic [STAKE_W-1:0] wr_data,
	input  logic               rd_en,
	input  logic [AW-1:0]      rd_addr,
	output logic [STAKE_W-1:0] rd_data
);

	logic [STAKE_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> design/stake_quorum_certificate_checker_top.sv
// Stake-weighted two-thirds quorum checker, top level.
// Uses scqc_pkg, scqc_addsub (shared adder) and scqc_stake_ram (stake table).
//
// Usage: the input channel (in_valid / in_stall) carries one request item:
// load a stake entry, begin a certificate, absorb a signer with the
// external verifier's verdict, or finish. Every item gives exactly one result
// item on the output channel (out_valid / out_stall): a status code and the
// certificate's phase, signer count and stake sum after the request.
// An item runs through a four-step sequencer: table read, add, compare,
// commit. All stake sums and compares go through one 67-bit adder, used
// once for the sum and once for the compare. The in_stall output is high
// from acceptance until the commit, so the block takes no new item until
// the one before it has been committed to the output register.
// The result sits in an output register: the next item is accepted while it
// waits, but its commit waits until that register is free, so a stalled
// receiver holds the block in its commit step.
// Reset clears the snapshot and the certificate (phase idle, stored verdict
// closed). The stake table itself is not cleared; only entries written by a
// load are ever used.
module stake_quorum_certificate_checker_top
	import scqc_pkg::*;
#(
	parameter int MAX_MEMBERS = 1024
)
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          req_type,
	input  logic [INDEX_W-1:0]  member_index,
	input  logic [STAKE_W-1:0]  stake_value,
	input  logic                last_stake,
	input  logic                signature_present,
	input  logic                signature_valid,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [2:0]          status,
	output logic [1:0]          cert_state,
	output logic [SIGNER_W-1:0] signer_total,
	output logic [STAKE_W-1:0]  stake_sum
);

	localparam int CW = $clog2(MAX_MEMBERS + 1);
	localparam int IW = (MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 1;

	seq_state_t state_q, state_n;

	req_t               req_q;
	logic [INDEX_W-1:0] idx_q;
	logic [STAKE_W-1:0] stake_q;
	logic               last_q;
	logic               present_q;
	logic               sigok_q;

	logic [ALU_W-1:0]   add_q;
	logic               neg_q;

	logic [CW-1:0]      load_pos_q, load_pos_n;
	logic [STAKE_W-1:0] pending_total_q, pending_total_n;
	logic               load_failed_q, load_failed_n;
	logic               snap_valid_q, snap_valid_n;
	logic [CW-1:0]      member_count_q, member_count_n;
	logic [STAKE_W-1:0] snapshot_total_q, snapshot_total_n;
	logic [CW-1:0]      cert_count_q, cert_count_n;
	logic [STAKE_W-1:0] cert_total_q, cert_total_n;
	logic [CW-1:0]      next_expected_q, next_expected_n;
	logic [CW-1:0]      signer_count_q, signer_count_n;
	logic [STAKE_W-1:0] running_sum_q, running_sum_n;
	phase_t             phase_q, phase_n;
	status_t            verdict_q, verdict_n;
	status_t            st_n;
	logic               ram_we_n;

	logic                out_valid_q;
	status_t             status_q;
	phase_t              cert_state_q;
	logic [SIGNER_W-1:0] signer_total_q;
	logic [STAKE_W-1:0]  stake_sum_q;

	logic               accept;
	logic               out_free;
	logic               commit;
	logic               fresh;
	logic [STAKE_W-1:0] pend_eff;
	logic               ram_rd_en;
	logic [STAKE_W-1:0] ram_rd_data;
	alu_req_t           alu_req;
	logic [ALU_W-1:0]   alu_res;

	scqc_addsub u_addsub (
		.req (alu_req),
		.res (alu_res)
	);

	scqc_stake_ram #(
		.DEPTH (MAX_MEMBERS),
		.AW    (IW)
	) u_stake_ram (
		.clk     (clk),
		.wr_en   (commit && ram_we_n),
		.wr_addr (load_pos_q[IW-1:0]),
		.wr_data (stake_q),
		.rd_en   (ram_rd_en),
		.rd_addr (idx_q[IW-1:0]),
		.rd_data (ram_rd_data)
	);

	assign fresh    = (load_pos_q == '0) && !load_failed_q;
	assign pend_eff = fresh ? '0 : pending_total_q;
	assign out_free = !out_valid_q || !out_stall;
	assign accept   = in_valid && !in_stall;
	assign commit   = (state_q == SQ_DONE) && out_free;

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			SQ_IDLE: if (in_valid) state_n = SQ_READ;
			SQ_READ: state_n = SQ_ADD;
			SQ_ADD:  state_n = SQ_CMP;
			SQ_CMP:  state_n = SQ_DONE;
			SQ_DONE: if (out_free) state_n = SQ_IDLE;
			default: state_n = SQ_IDLE;
		endcase
	end

	always_comb begin
		in_stall    = (state_q != SQ_IDLE);
		ram_rd_en   = (state_q == SQ_READ);
		alu_req.a   = {3'b000, running_sum_q};
		alu_req.b   = {3'b000, ram_rd_data};
		alu_req.cin = 1'b0;
		unique case (state_q)
			SQ_ADD: begin
				case (req_q)
					REQ_LOAD: begin
						alu_req.a = {3'b000, pend_eff};
						alu_req.b = {3'b000, stake_q};
					end
					REQ_FINISH: begin
						alu_req.a = {2'b00, running_sum_q, 1'b0};
						alu_req.b = {3'b000, running_sum_q};
					end
					default: begin
						alu_req.a = {3'b000, running_sum_q};
						alu_req.b = {3'b000, ram_rd_data};
					end
				endcase
			end
			SQ_CMP: begin
				alu_req.cin = 1'b1;
				if (req_q == REQ_FINISH) begin
					alu_req.a = add_q;
					alu_req.b = ~{2'b00, cert_total_q, 1'b0};
				end else begin
					alu_req.a = {3'b000, cert_total_q};
					alu_req.b = ~add_q;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		load_pos_n       = load_pos_q;
		pending_total_n  = pending_total_q;
		load_failed_n    = load_failed_q;
		snap_valid_n     = snap_valid_q;
		member_count_n   = member_count_q;
		snapshot_total_n = snapshot_total_q;
		cert_count_n     = cert_count_q;
		cert_total_n     = cert_total_q;
		next_expected_n  = next_expected_q;
		signer_count_n   = signer_count_q;
		running_sum_n    = running_sum_q;
		phase_n          = phase_q;
		verdict_n        = verdict_q;
		st_n             = ST_OK;
		ram_we_n         = 1'b0;
		unique case (req_q)
			REQ_LOAD: begin
				if (fresh) begin
					snap_valid_n = 1'b0;
				end
				pending_total_n = pend_eff;
				if (load_failed_q) begin
					st_n = ST_SNAPSHOT;
				end else if (stake_q == '0 || add_q[STAKE_W] ||
						load_pos_q >= CW'(MAX_MEMBERS)) begin
					load_failed_n = 1'b1;
					st_n          = ST_SNAPSHOT;
				end else begin
					ram_we_n        = 1'b1;
					pending_total_n = add_q[STAKE_W-1:0];
					load_pos_n      = load_pos_q + 1'b1;
				end
				if (last_q) begin
					if (!load_failed_n) begin
						member_count_n   = load_pos_n;
						snapshot_total_n = pending_total_n;
						snap_valid_n     = 1'b1;
					end else begin
						snap_valid_n = 1'b0;
						st_n         = ST_SNAPSHOT;
					end
					load_pos_n      = '0;
					pending_total_n = '0;
					load_failed_n   = 1'b0;
				end
			end
			REQ_BEGIN: begin
				if (!snap_valid_q || member_count_q == '0 || snapshot_total_q == '0) begin
					st_n = ST_SNAPSHOT;
				end else begin
					cert_count_n    = member_count_q;
					cert_total_n    = snapshot_total_q;
					next_expected_n = '0;
					signer_count_n  = '0;
					running_sum_n   = '0;
					phase_n         = PH_OPEN;
					verdict_n       = ST_OK;
				end
			end
			REQ_ABSORB: begin
				if (phase_q == PH_ACCEPTED) begin
					st_n = ST_CLOSED;
				end else if (phase_q != PH_OPEN) begin
					st_n = ST_CLOSED;
				end else if (!present_q) begin
					st_n = ST_ARGUMENT;
				end else if (idx_q < INDEX_W'(next_expected_q)) begin
					st_n = ST_ORDER;
				end else if (idx_q >= INDEX_W'(cert_count_q) ||
						{1'b0, idx_q} >= (INDEX_W + 1)'(MAX_MEMBERS)) begin
					st_n = ST_RANGE;
				end else if (neg_q) begin
					st_n = ST_SNAPSHOT;
				end else if (!sigok_q) begin
					st_n = ST_SIGNATURE;
				end else begin
					running_sum_n   = add_q[STAKE_W-1:0];
					next_expected_n = idx_q[CW-1:0] + 1'b1;
					signer_count_n  = signer_count_q + 1'b1;
				end
				if (phase_q == PH_ACCEPTED || (phase_q == PH_OPEN && st_n != ST_OK)) begin
					phase_n   = PH_REJECTED;
					verdict_n = st_n;
				end
			end
			REQ_FINISH: begin
				if (phase_q != PH_OPEN) begin
					st_n = verdict_q;
				end else if (!neg_q) begin
					phase_n   = PH_ACCEPTED;
					verdict_n = ST_OK;
				end else begin
					st_n      = ST_BELOW;
					phase_n   = PH_REJECTED;
					verdict_n = ST_BELOW;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q     <= req_t'(req_type);
			idx_q     <= member_index;
			stake_q   <= stake_value;
			last_q    <= last_stake;
			present_q <= signature_present;
			sigok_q   <= signature_valid;
		end
		if (state_q == SQ_ADD) begin
			add_q <= alu_res;
		end
		if (state_q == SQ_CMP) begin
			neg_q <= alu_res[ALU_W-1];
		end
		if (commit) begin
			status_q       <= st_n;
			cert_state_q   <= phase_n;
			signer_total_q <= SIGNER_W'(signer_count_n);
			stake_sum_q    <= running_sum_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= SQ_IDLE;
			out_valid_q      <= 1'b0;
			load_pos_q       <= '0;
			pending_total_q  <= '0;
			load_failed_q    <= 1'b0;
			snap_valid_q     <= 1'b0;
			member_count_q   <= '0;
			snapshot_total_q <= '0;
			cert_count_q     <= '0;
			cert_total_q     <= '0;
			next_expected_q  <= '0;
			signer_count_q   <= '0;
			running_sum_q    <= '0;
			phase_q          <= PH_IDLE;
			verdict_q        <= ST_CLOSED;
		end else begin
			state_q     <= state_n;
			out_valid_q <= commit || (out_valid_q && out_stall);
			if (commit) begin
				load_pos_q       <= load_pos_n;
				pending_total_q  <= pending_total_n;
				load_failed_q    <= load_failed_n;
				snap_valid_q     <= snap_valid_n;
				member_count_q   <= member_count_n;
				snapshot_total_q <= snapshot_total_n;
				cert_count_q     <= cert_count_n;
				cert_total_q     <= cert_total_n;
				next_expected_q  <= next_expected_n;
				signer_count_q   <= signer_count_n;
				running_sum_q    <= running_sum_n;
				phase_q          <= phase_n;
				verdict_q        <= verdict_n;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign cert_state   = cert_state_q;
	assign signer_total = signer_total_q;
	assign stake_sum    = stake_sum_q;

	a_accept_starts_read: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == SQ_READ)
		else $error("accepted item did not start the sequencer");

	a_commit_waits: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == SQ_DONE && out_valid_q && out_stall |=> state_q == SQ_DONE)
		else $error("commit overran a waiting result");

	a_sum_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		running_sum_q <= cert_total_q)
		else $error("running sum exceeds certificate total");

	a_accepted_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_ACCEPTED |-> verdict_q == ST_OK)
		else $error("accepted certificate with failing verdict");

endmodule
